FILE: design/cubic_trajectory_rehab_sequencer_core_defines.svh
// Assertion macros for the cubic trajectory sequencer.
// No dependencies; included by the checker file.
`ifndef CUBIC_TRAJECTORY_REHAB_SEQUENCER_CORE_DEFINES_SVH
`define CUBIC_TRAJECTORY_REHAB_SEQUENCER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define CTRS_CHECK(lbl, prop, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Antecedent in this cycle implies consequent in the next one
`define CTRS_CHECK_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ctrs_pkg.sv
// Shared types and constants for the cubic trajectory sequencer.
// No dependencies; imported by every module of the block.
package ctrs_pkg;

   // Default geometry
   localparam int ANGLE_BITS_DEF = 8;
   localparam int TIME_BITS_DEF  = 10;

   // Configuration registers
   localparam int DUR_W      = 10;
   localparam int AMP_W      = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(100);
   localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(60);

   localparam logic [CSR_IDX_W-1:0] CSR_DURATION  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE = 1'b1;

   // Segment codes
   localparam logic [1:0] SEG_TO_ZERO = 2'd0;
   localparam logic [1:0] SEG_TO_POS  = 2'd1;
   localparam logic [1:0] SEG_TO_NEG  = 2'd2;
   localparam logic [1:0] SEG_RETURN  = 2'd3;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_START = 2'd1,
      ACT_SET   = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   // Evaluation sequence: six products, then the division
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TT,
      ST_T3,
      ST_SQ,
      ST_P,
      ST_NUM0,
      ST_NUM1,
      ST_DIV,
      ST_FIN
   } seq_state_type;

   // Controls from the sequencer to the serial multiplier
   typedef struct packed {
      logic go;
      logic clear;
      logic signed_b;
   } mul_ctl_type;

endpackage

FILE: design/ctrs_serial_mul.sv
// Bit-serial shift-add multiplier with accumulate, one multiplier bit per cycle.
// Depends on ctrs_pkg.
module ctrs_serial_mul #(
   parameter int NW  = 39,
   parameter int BW  = 12,
   parameter int MCW = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrs_pkg::mul_ctl_type ctl,
   input  logic [NW-1:0]        a,
   input  logic [BW-1:0]        b,
   input  logic [MCW-1:0]       nbits,
   output logic                 busy,
   output logic [NW-1:0]        acc
);
   import ctrs_pkg::*;

   logic [NW-1:0]  acc_ff;
   logic [NW-1:0]  a_sh_ff;
   logic [BW-1:0]  b_sh_ff;
   logic [MCW-1:0] cnt_ff;
   logic           signed_ff;
   logic           last_neg;

   // top bit of a signed multiplier carries negative weight
   assign last_neg = signed_ff && (cnt_ff == MCW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctl.go) begin
         cnt_ff    <= nbits;
         a_sh_ff   <= a;
         b_sh_ff   <= b;
         signed_ff <= ctl.signed_b;
         if (ctl.clear) begin
            acc_ff <= '0;
         end
      end else if (cnt_ff != '0) begin
         if (b_sh_ff[0]) begin
            acc_ff <= last_neg ? (acc_ff - a_sh_ff) : (acc_ff + a_sh_ff);
         end
         a_sh_ff <= a_sh_ff << 1;
         b_sh_ff <= b_sh_ff >> 1;
         cnt_ff  <= cnt_ff - MCW'(1);
      end
   end

   assign busy = (cnt_ff != '0);
   assign acc  = acc_ff;

endmodule

FILE: design/ctrs_serial_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on ctrs_pkg.
module ctrs_serial_div #(
   parameter int NW  = 39,
   parameter int DW  = 30,
   parameter int QW  = 8,
   parameter int DCW = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic signed [NW-1:0] num,
   input  logic [DW-1:0]        den,
   output logic                 busy,
   output logic signed [QW-1:0] quot
);
   import ctrs_pkg::*;

   logic [NW-1:0]  rem_ff;
   logic [NW-1:0]  den_sh_ff;
   logic [QW-1:0]  q_ff;
   logic [DCW-1:0] cnt_ff;
   logic           neg_ff;
   logic           ge;

   assign ge = (rem_ff >= den_sh_ff);

   // magnitude divide; quotient is known to fit QW bits
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (go) begin
         neg_ff    <= num[NW-1];
         rem_ff    <= num[NW-1] ? (-num) : num;
         den_sh_ff <= NW'(den) << (QW - 1);
         q_ff      <= '0;
         cnt_ff    <= DCW'(QW);
      end else if (cnt_ff != '0) begin
         if (ge) begin
            rem_ff <= rem_ff - den_sh_ff;
         end
         q_ff      <= {q_ff[QW-2:0], ge};
         den_sh_ff <= den_sh_ff >> 1;
         cnt_ff    <= cnt_ff - DCW'(1);
      end
   end

   assign busy = (cnt_ff != '0);
   assign quot = neg_ff ? (-$signed(q_ff)) : $signed(q_ff);

endmodule

FILE: design/cubic_trajectory_rehab_sequencer_core.sv
// Cubic point-to-point joint trajectory sequencer, top level.
// Depends on ctrs_pkg, ctrs_serial_mul and ctrs_serial_div.
//
// Usage:
//   req_* carries one command per transaction: tick, start sequence, set angle
//   or no-op. Each command yields exactly one rsp_* transaction with the joint
//   angle, busy flag, running segment and end-of-sequence flag.
//   csr_* writes duration_ticks (index 0) and amplitude (index 1); csr_ready
//   is always high. Write configuration only while no command is in flight.
// Evaluation:
//   A tick while a sequence runs evaluates the cubic with one shared
//   bit-serial multiplier (six products) and a serial divider, then
//   responds from the commit state. All other commands, and a tick while no
//   sequence runs, respond in the next cycle.
//   One command is processed at a time; req_stall is high while a tick is
//   evaluated.
// Reset: synchronous, clears angle, sequence state and the result valid flag,
//   and loads duration 100 and amplitude 60.
// Output stall: the result register holds its payload while rsp_stall is
//   high, and no new command is accepted until it drains.
module cubic_trajectory_rehab_sequencer_core #(
   parameter int ANGLE_BITS = ctrs_pkg::ANGLE_BITS_DEF,
   parameter int TIME_BITS  = ctrs_pkg::TIME_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // command channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_action,
   input  logic signed [ANGLE_BITS-1:0]     req_new_angle,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [ANGLE_BITS-1:0]     rsp_angle,
   output logic                             rsp_busy_res,
   output logic [1:0]                       rsp_segment,
   output logic                             rsp_sequence_done,
   // configuration
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ctrs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ctrs_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ctrs_pkg::*;

   localparam int AB   = ANGLE_BITS;
   localparam int TW   = TIME_BITS;
   localparam int T3W  = 3 * TW;
   localparam int NW   = AB + T3W + 1;
   localparam int BW   = (TW + 2 > AB) ? (TW + 2) : AB;
   localparam int MCW  = $clog2(BW + 1);
   localparam int DCW  = $clog2(AB + 1);
   localparam int CTW  = (TW > DUR_W) ? TW : DUR_W;
   localparam int EW   = ((AMP_W > AB) ? AMP_W : AB) + 1;

   localparam logic [TW-1:0]        TIME_MAX  = '1;
   localparam logic signed [AB-1:0] ANG_MAX   = {1'b0, {(AB - 1){1'b1}}};
   localparam logic signed [AB-1:0] ANG_MIN   = {1'b1, {(AB - 1){1'b0}}};
   localparam logic [EW-1:0]        ANG_MAX_E = EW'($unsigned(ANG_MAX));

   // Excursion target of a segment, saturated to the angle range
   function automatic logic signed [AB-1:0] target_of(input logic [1:0] seg,
                                                      input logic [AMP_W-1:0] amp);
      logic [EW-1:0]        amp_e;
      logic signed [AB-1:0] res;
      amp_e = EW'(amp);
      res   = '0;
      if (seg == SEG_TO_POS) begin
         res = (amp_e > ANG_MAX_E) ? ANG_MAX : AB'(amp);
      end else if (seg == SEG_TO_NEG) begin
         res = (amp_e > (ANG_MAX_E + EW'(1))) ? ANG_MIN : (-AB'(amp));
      end
      return res;
   endfunction

   // Configuration and architectural state
   logic [DUR_W-1:0]        dur_ff;
   logic [AMP_W-1:0]        amp_ff;
   logic signed [AB-1:0]    cur_ff, cur_in;
   logic signed [AB-1:0]    start_ff, start_in;
   logic signed [AB-1:0]    target_ff, target_in;
   logic [TW-1:0]           time_ff, time_in;
   logic [1:0]              seg_ff, seg_in;
   logic                    run_ff, run_in;
   seq_state_type           state_ff, state_in;
   logic                    issued_ff, issued_in;

   // Evaluation operands
   logic [TW-1:0]           teff_ff;
   logic [TW-1:0]           t_ff;
   logic [T3W-1:0]          prod_ff;
   logic [T3W-1:0]          t3_ff;
   logic [T3W-1:0]          p_ff;

   // Result register
   logic                    rsp_valid_ff;
   logic signed [AB-1:0]    rsp_angle_ff;
   logic                    rsp_busy_ff;
   logic [1:0]              rsp_seg_ff;
   logic                    rsp_done_ff;
   logic                    rsp_load;
   logic                    done_in;

   // Datapath glue
   logic                    rsp_free;
   logic                    req_fire;
   action_type              act;
   logic [DUR_W-1:0]        dur_nz;
   logic [CTW-1:0]          dur_x;
   logic [TW-1:0]           teff;
   logic [TW-1:0]           t_sel;
   logic [TW+1:0]           q_poly;
   logic                    step_done;

   mul_ctl_type             mul_ctl;
   logic [NW-1:0]           mul_a;
   logic [BW-1:0]           mul_b;
   logic [MCW-1:0]          mul_nbits;
   logic                    mul_busy;
   logic [NW-1:0]           mul_acc;
   logic                    div_go;
   logic                    div_busy;
   logic signed [AB-1:0]    div_quot;

   // Handshakes
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && rsp_free);
   assign req_fire  = req_valid && !req_stall;
   assign act       = action_type'(req_action);
   assign csr_ready = 1'b1;

   // Effective segment time: zero acts as one, clamp to the time range
   assign dur_nz = (dur_ff == '0) ? DUR_W'(1) : dur_ff;
   assign dur_x  = CTW'(dur_nz);
   assign teff   = (dur_x > CTW'(TIME_MAX)) ? TIME_MAX : TW'(dur_x);
   assign t_sel  = (time_ff > teff) ? teff : time_ff;

   // 3T - 2t, never negative since t <= T
   assign q_poly = ((TW + 2)'(teff_ff) << 1) + (TW + 2)'(teff_ff)
                 - ((TW + 2)'(t_ff) << 1);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff <= DUR_RESET;
         amp_ff <= AMP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DURATION:  dur_ff <= csr_data[DUR_W-1:0];
            CSR_AMPLITUDE: amp_ff <= csr_data[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: next state, operand selection and result formation
   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      start_in  = start_ff;
      target_in = target_ff;
      time_in   = time_ff;
      seg_in    = seg_ff;
      run_in    = run_ff;
      rsp_load  = 1'b0;
      done_in   = 1'b0;
      mul_ctl   = '0;
      mul_a     = '0;
      mul_b     = '0;
      mul_nbits = '0;
      div_go    = 1'b0;
      step_done = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (act)
                  ACT_TICK: begin
                     if (run_ff) begin
                        state_in = ST_TT;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  ACT_START: begin
                     rsp_load = 1'b1;
                     if (!run_ff) begin
                        run_in   = 1'b1;
                        time_in  = '0;
                        start_in = cur_ff;
                        if (cur_ff != '0) begin
                           seg_in    = SEG_TO_ZERO;
                           target_in = '0;
                        end else begin
                           seg_in    = SEG_TO_POS;
                           target_in = target_of(SEG_TO_POS, amp_ff);
                        end
                     end
                  end
                  ACT_SET: begin
                     rsp_load = 1'b1;
                     if (!run_ff) begin
                        cur_in = req_new_angle;
                     end
                  end
                  ACT_NOP: rsp_load = 1'b1;
               endcase
            end
         end
         // T*T
         ST_TT: begin
            mul_ctl.go    = !issued_ff;
            mul_ctl.clear = 1'b1;
            mul_a         = NW'(teff_ff);
            mul_b         = BW'(teff_ff);
            mul_nbits     = MCW'(TW);
            step_done     = issued_ff && !mul_busy;
            if (step_done) state_in = ST_T3;
         end
         // T^3
         ST_T3: begin
            mul_ctl.go    = !issued_ff;
            mul_ctl.clear = 1'b1;
            mul_a         = NW'(prod_ff);
            mul_b         = BW'(teff_ff);
            mul_nbits     = MCW'(TW);
            step_done     = issued_ff && !mul_busy;
            if (step_done) state_in = ST_SQ;
         end
         // t*t
         ST_SQ: begin
            mul_ctl.go    = !issued_ff;
            mul_ctl.clear = 1'b1;
            mul_a         = NW'(t_ff);
            mul_b         = BW'(t_ff);
            mul_nbits     = MCW'(TW);
            step_done     = issued_ff && !mul_busy;
            if (step_done) state_in = ST_P;
         end
         // p = t^2 * (3T - 2t)
         ST_P: begin
            mul_ctl.go    = !issued_ff;
            mul_ctl.clear = 1'b1;
            mul_a         = NW'(prod_ff);
            mul_b         = BW'(q_poly);
            mul_nbits     = MCW'(TW + 2);
            step_done     = issued_ff && !mul_busy;
            if (step_done) state_in = ST_NUM0;
         end
         // start * (T^3 - p)
         ST_NUM0: begin
            mul_ctl.go       = !issued_ff;
            mul_ctl.clear    = 1'b1;
            mul_ctl.signed_b = 1'b1;
            mul_a            = NW'(t3_ff - p_ff);
            mul_b            = BW'($unsigned(start_ff));
            mul_nbits        = MCW'(AB);
            step_done        = issued_ff && !mul_busy;
            if (step_done) state_in = ST_NUM1;
         end
         // + target * p
         ST_NUM1: begin
            mul_ctl.go       = !issued_ff;
            mul_ctl.signed_b = 1'b1;
            mul_a            = NW'(p_ff);
            mul_b            = BW'($unsigned(target_ff));
            mul_nbits        = MCW'(AB);
            step_done        = issued_ff && !mul_busy;
            if (step_done) state_in = ST_DIV;
         end
         ST_DIV: begin
            div_go    = !issued_ff;
            step_done = issued_ff && !div_busy;
            if (step_done) state_in = ST_FIN;
         end
         // Commit the new angle, then advance the time or the segment, or end the sequence
         ST_FIN: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
               rsp_load = 1'b1;
               cur_in   = div_quot;
               if (t_ff >= teff_ff) begin
                  time_in = '0;
                  if (seg_ff == SEG_RETURN) begin
                     run_in  = 1'b0;
                     seg_in  = SEG_TO_ZERO;
                     done_in = 1'b1;
                  end else begin
                     seg_in    = seg_ff + 2'd1;
                     start_in  = div_quot;
                     target_in = target_of(seg_ff + 2'd1, amp_ff);
                  end
               end else begin
                  time_in = t_ff + TW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      issued_in = (state_in == state_ff) && (state_ff != ST_IDLE)
               && (state_ff != ST_FIN);
   end

   // Control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
         cur_ff    <= '0;
         start_ff  <= '0;
         target_ff <= '0;
         time_ff   <= '0;
         seg_ff    <= SEG_TO_ZERO;
         run_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         cur_ff    <= cur_in;
         start_ff  <= start_in;
         target_ff <= target_in;
         time_ff   <= time_in;
         seg_ff    <= seg_in;
         run_ff    <= run_in;
      end
   end

   // Operand capture between serial passes
   always_ff @(posedge clock) begin
      if (req_fire) begin
         teff_ff <= teff;
         t_ff    <= t_sel;
      end
      if (step_done) begin
         case (state_ff)
            ST_TT, ST_SQ: prod_ff <= mul_acc[T3W-1:0];
            ST_T3:        t3_ff   <= mul_acc[T3W-1:0];
            ST_P:         p_ff    <= mul_acc[T3W-1:0];
            default: ;
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_angle_ff <= cur_in;
         rsp_busy_ff  <= run_in;
         rsp_seg_ff   <= run_in ? seg_in : SEG_TO_ZERO;
         rsp_done_ff  <= done_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_angle         = rsp_angle_ff;
   assign rsp_busy_res      = rsp_busy_ff;
   assign rsp_segment       = rsp_seg_ff;
   assign rsp_sequence_done = rsp_done_ff;

   ctrs_serial_mul #(
      .NW  (NW),
      .BW  (BW),
      .MCW (MCW)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_ctl),
      .a     (mul_a),
      .b     (mul_b),
      .nbits (mul_nbits),
      .busy  (mul_busy),
      .acc   (mul_acc)
   );

   ctrs_serial_div #(
      .NW  (NW),
      .DW  (T3W),
      .QW  (AB),
      .DCW (DCW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   ($signed(mul_acc)),
      .den   (t3_ff),
      .busy  (div_busy),
      .quot  (div_quot)
   );

endmodule

FILE: design/ctrs_checker.sv
// Port-level checker for the cubic trajectory sequencer, bound to the top level.
// Depends on ctrs_pkg and cubic_trajectory_rehab_sequencer_core_defines.svh.
`include "cubic_trajectory_rehab_sequencer_core_defines.svh"

module ctrs_checker #(
   parameter int ANGLE_BITS = ctrs_pkg::ANGLE_BITS_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic signed [ANGLE_BITS-1:0]     rsp_angle,
   input logic                             rsp_busy_res,
   input logic [1:0]                       rsp_segment,
   input logic                             rsp_sequence_done
);
   import ctrs_pkg::*;

   // A stalled result keeps its payload
   `CTRS_CHECK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_angle) && $stable(rsp_segment), "stalled transaction changed")

   // No new command while the result register cannot drain
   `CTRS_CHECK(a_backpressure, rsp_valid && rsp_stall |-> req_stall, "command accepted under output stall")

   // Segment reads zero whenever no sequence runs
   `CTRS_CHECK(a_seg_idle, rsp_valid && !rsp_busy_res |-> rsp_segment == SEG_TO_ZERO, "segment nonzero while idle")

   // The finishing tick lands exactly on zero and drops busy
   `CTRS_CHECK(a_done_home, rsp_valid && rsp_sequence_done |-> !rsp_busy_res && rsp_angle == '0, "sequence end not at rest")

endmodule

bind cubic_trajectory_rehab_sequencer_core ctrs_checker #(
   .ANGLE_BITS (ANGLE_BITS)
) u_ctrs_checker (.*);
